[sv/bts_pkg.sv]
// Shared constants, codes and types of the bright text strip patcher.
package bts_pkg;

    // Sizing of the strip store.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_STRIP   = 32;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SROW_W      = $clog2(MAX_STRIP);
    localparam int PIX_ADDR_W  = SROW_W + COL_W;
    localparam int PIX_DEPTH   = MAX_STRIP * MAX_WIDTH;

    // Field widths of the ports.
    localparam int ROW_W       = 12;
    localparam int CMP_W       = ROW_W + 1;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_STRIP_W = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CFG_WIDTH_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_ROWS  = 1'd1;

    // Pixel constants.
    localparam logic [7:0]       BRIGHT_LEVEL = 8'd180;
    localparam logic [7:0]       FULL_ALPHA   = 8'd255;
    localparam logic [ROW_W-1:0] ROW_LIMIT    = 12'd4095;

    // Output queue sizing.
    localparam int MAX_RESULTS = 2;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    // What a pixel does, decided by its row.
    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_PATCH,
        KIND_PASS
    } kind_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    // One accepted pixel with its position and neighborhood bounds.
    typedef struct packed {
        kind_t                kind;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [SROW_W-1:0]    py;
        logic [COL_W-1:0]     x0;
        logic [COL_W-1:0]     x1;
        logic [MAX_STRIP-1:0] row_mask;
        logic                 mark;
        pixel_t               pix;
    } item_t;

    // One output word.
    typedef struct packed {
        pixel_t           pix;
        logic             fix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } result_t;

endpackage

[sv/bright_text_strip_patcher.sv]
// Top level of the bright text strip patcher: strip memories, patch pipeline, output queue.
//
//   channel   direction   handshake             word
//   input     in          in_valid / in_stall   frame_start, in_red .. in_alpha
//   output    out         out_valid / out_stall out_red .. out_alpha, is_strip_fix,
//                                               pixel_row, pixel_col, run_last
//   config    in          cfg_we                cfg_index, cfg_data
//
// The 3x3 mark test needs three column reads of the mark memory, which has two read
// ports (two copies written alike).
// A pixel's words are pushed into the output queue from pipeline stage s2, after s1.
// Reset clears counters, pipeline and queue; the strip memories are not cleared.
// The input stalls in the cycle after an acceptance and while the eight-word output
// queue could not take the words of every pixel in flight.
module bright_text_strip_patcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            frame_start,
    input  logic [7:0]                      in_red,
    input  logic [7:0]                      in_green,
    input  logic [7:0]                      in_blue,
    input  logic [7:0]                      in_alpha,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue,
    output logic [7:0]                      out_alpha,
    output logic                            is_strip_fix,
    output logic [bts_pkg::ROW_W-1:0]       pixel_row,
    output logic [bts_pkg::COL_W-1:0]       pixel_col,
    output logic                            run_last
);

    import bts_pkg::*;

    logic   in_accept;
    pixel_t in_pix;
    item_t  cur_item;

    logic  s1_valid_reg;
    item_t s1_item_reg;
    logic  s2_valid_reg;
    item_t s2_item_reg;
    logic [MAX_STRIP-1:0] s2_word_a_reg;
    logic [MAX_STRIP-1:0] s2_word_b_reg;
    pixel_t               s2_stored_reg;

    logic                  mark_we;
    logic [COL_W-1:0]      mark_waddr;
    logic [MAX_STRIP-1:0]  mark_wdata;
    logic [MAX_STRIP-1:0]  mark_bit;
    logic [COL_W-1:0]      mark_a_raddr;
    logic [MAX_STRIP-1:0]  mark_a_rdata;
    logic [MAX_STRIP-1:0]  mark_b_rdata;
    logic                  pix_we;
    logic [PIX_ADDR_W-1:0] pix_waddr;
    logic [PIX_ADDR_W-1:0] pix_raddr;
    pixel_t                pix_rdata;

    logic                  hit;
    pixel_t                patched;
    result_t               res_fix;
    result_t               res_pass;
    logic [1:0]            push_n;
    result_t               push_data0;
    result_t               push_data1;
    logic [1:0]            pend;
    logic [OUTQ_CNT_W:0]   need;
    logic                  out_pop;
    result_t               q_head;
    logic                  q_not_empty;
    logic [OUTQ_CNT_W-1:0] q_count;

    assign in_pix.red   = in_red;
    assign in_pix.green = in_green;
    assign in_pix.blue  = in_blue;
    assign in_pix.alpha = in_alpha;
    assign in_accept    = in_valid && !in_stall;

    bts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (in_accept),
        .frame_start (frame_start),
        .pix         (in_pix),
        .item        (cur_item)
    );

    // Memory addresses: the accept cycle reads the left and center columns,
    // the following cycle reads the right column on the first copy.
    assign mark_a_raddr = s1_valid_reg ? s1_item_reg.x1 : cur_item.x0;
    assign pix_we       = in_accept && (cur_item.kind == KIND_STORE);
    assign pix_waddr    = {cur_item.row[SROW_W-1:0], cur_item.col};
    assign pix_raddr    = {cur_item.py, cur_item.col};

    // Mark update of a stored pixel: the column word read at acceptance gets
    // this row's bit replaced and is written back in the cycle after.
    always_comb
    begin
        mark_bit   = MAX_STRIP'(1) << s1_item_reg.row[SROW_W-1:0];
        mark_we    = s1_valid_reg && (s1_item_reg.kind == KIND_STORE);
        mark_waddr = s1_item_reg.col;
        mark_wdata = (mark_b_rdata & ~mark_bit) | (s1_item_reg.mark ? mark_bit : '0);
    end

    bts_ram #(
        .WIDTH (MAX_STRIP),
        .DEPTH (MAX_WIDTH)
    ) u_mark_a (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_a_raddr),
        .rdata (mark_a_rdata)
    );

    bts_ram #(
        .WIDTH (MAX_STRIP),
        .DEPTH (MAX_WIDTH)
    ) u_mark_b (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (cur_item.col),
        .rdata (mark_b_rdata)
    );

    bts_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (PIX_DEPTH)
    ) u_pix (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (in_pix),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload: the item and the data read at acceptance.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= cur_item;
        end
        s2_item_reg   <= s1_item_reg;
        s2_word_a_reg <= mark_a_rdata;
        s2_word_b_reg <= mark_b_rdata;
        s2_stored_reg <= pix_rdata;
    end

    // Patch decision with the right column word just read.
    always_comb
    begin
        hit = |((s2_word_a_reg | s2_word_b_reg | mark_a_rdata) & s2_item_reg.row_mask);
        patched       = hit ? s2_item_reg.pix : s2_stored_reg;
        patched.alpha = hit ? FULL_ALPHA : s2_stored_reg.alpha;

        res_fix.pix   = patched;
        res_fix.fix   = 1'b1;
        res_fix.row   = ROW_W'(s2_item_reg.py);
        res_fix.col   = s2_item_reg.col;
        res_fix.last  = 1'b0;

        res_pass.pix  = s2_item_reg.pix;
        res_pass.fix  = 1'b0;
        res_pass.row  = s2_item_reg.row;
        res_pass.col  = s2_item_reg.col;
        res_pass.last = 1'b1;
    end

    // Words of the finished pixel into the queue.
    always_comb
    begin
        push_data0 = res_pass;
        push_data1 = res_pass;
        pend       = 2'd0;
        case (s2_item_reg.kind)
            KIND_PATCH:
            begin
                pend       = 2'd2;
                push_data0 = res_fix;
            end
            KIND_PASS:
            begin
                pend = 2'd1;
            end
            default:
            begin
                pend = 2'd0;
            end
        endcase
        push_n = s2_valid_reg ? pend : 2'd0;
    end

    // Accept only when the queue is sure to hold the words of every pixel in flight.
    always_comb
    begin
        need     = (OUTQ_CNT_W+1)'(q_count) + (OUTQ_CNT_W+1)'(push_n)
                   + (OUTQ_CNT_W+1)'(MAX_RESULTS);
        in_stall = s1_valid_reg || (need > (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
    end

    assign out_pop = q_not_empty && !out_stall;

    bts_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .pop        (out_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    assign out_valid    = q_not_empty;
    assign out_red      = q_head.pix.red;
    assign out_green    = q_head.pix.green;
    assign out_blue     = q_head.pix.blue;
    assign out_alpha    = q_head.pix.alpha;
    assign is_strip_fix = q_head.fix;
    assign pixel_row    = q_head.row;
    assign pixel_col    = q_head.col;
    assign run_last     = q_head.last;

`ifndef SYNTHESIS
    // Two pixels are never accepted back to back.
    a_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_accept)
        else $error("pixel accepted during the second cycle of the previous one");

    // The first pipeline stage holds only a pixel accepted at the previous edge.
    a_stage_one: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(in_accept))
        else $error("pipeline stage valid without an accepted pixel");

    // The queue never takes more words than it holds.
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("output queue overflow");
`endif

endmodule

[sv/bts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read the old contents into a registered read data output.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/bts_front.sv]
// Configuration registers, raster position counters and pixel classification.
module bts_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    input  logic                             frame_start,
    input  bts_pkg::pixel_t                  pix,
    output bts_pkg::item_t                   item
);

    import bts_pkg::*;

    logic [CFG_WIDTH_W-1:0] image_width_reg;
    logic [CFG_STRIP_W-1:0] strip_rows_reg;
    logic [ROW_W-1:0]       row_count_reg;
    logic [ROW_W-1:0]       row_count_next;
    logic [COL_W-1:0]       col_count_reg;
    logic [COL_W-1:0]       col_count_next;

    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] s_eff;
    logic [CMP_W-1:0] width_x;
    logic [CMP_W-1:0] strip_x;
    logic [ROW_W-1:0] row_c;
    logic [COL_W-1:0] col_c;
    logic [CMP_W-1:0] row_x;
    logic [CMP_W-1:0] col_x;
    logic [CMP_W-1:0] col_inc_x;
    logic [CMP_W-1:0] py_x;
    logic [CMP_W-1:0] y0_x;
    logic [CMP_W-1:0] y1_x;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= CFG_WIDTH_W'(1);
            strip_rows_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[CFG_WIDTH_W-1:0];
                REG_STRIP_ROWS:  strip_rows_reg  <= cfg_data[CFG_STRIP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Effective width and strip height, clamped to what the store holds; a width of zero counts as one.
    always_comb
    begin
        width_x = CMP_W'(image_width_reg);
        strip_x = CMP_W'(strip_rows_reg);
        if (width_x == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (width_x > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_x;
        end
        s_eff = (strip_x > CMP_W'(MAX_STRIP)) ? CMP_W'(MAX_STRIP) : strip_x;
    end

    // Position of the pixel on the input, and its role in the image.
    always_comb
    begin
        row_c     = frame_start ? '0 : row_count_reg;
        col_c     = frame_start ? '0 : col_count_reg;
        row_x     = CMP_W'(row_c);
        col_x     = CMP_W'(col_c);
        col_inc_x = col_x + CMP_W'(1);
        py_x      = row_x - s_eff;
        y0_x      = (py_x == '0) ? '0 : py_x - CMP_W'(1);
        y1_x      = ((py_x + CMP_W'(1)) < s_eff) ? py_x + CMP_W'(1) : s_eff - CMP_W'(1);

        if (row_x < s_eff)
        begin
            item.kind = KIND_STORE;
        end
        else if (row_x < (s_eff << 1))
        begin
            item.kind = KIND_PATCH;
        end
        else
        begin
            item.kind = KIND_PASS;
        end

        item.row  = row_c;
        item.col  = col_c;
        item.py   = py_x[SROW_W-1:0];
        item.x0   = (col_c == '0) ? '0 : col_c - COL_W'(1);
        item.x1   = (col_inc_x < w_eff) ? col_inc_x[COL_W-1:0] : col_c;
        for (int j = 0; j < MAX_STRIP; j++)
        begin
            item.row_mask[j] = (CMP_W'(j) >= y0_x) && (CMP_W'(j) <= y1_x);
        end
        item.mark = (pix.red > BRIGHT_LEVEL) && (pix.green > BRIGHT_LEVEL)
                    && (pix.blue > BRIGHT_LEVEL);
        item.pix  = pix;
    end

    // Raster counters: wrap at the row end, the row count saturates.
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept)
        begin
            if (col_inc_x >= w_eff)
            begin
                col_count_next = '0;
                row_count_next = (row_c < ROW_LIMIT) ? row_c + ROW_W'(1) : row_c;
            end
            else
            begin
                col_count_next = col_inc_x[COL_W-1:0];
                row_count_next = row_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

endmodule

[sv/bts_outq.sv]
// Output queue that takes up to two words a cycle and hands out one.
module bts_outq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [1:0]                      push_n,
    input  bts_pkg::result_t                push_data0,
    input  bts_pkg::result_t                push_data1,
    input  logic                            pop,
    output bts_pkg::result_t                head,
    output logic                            not_empty,
    output logic [bts_pkg::OUTQ_CNT_W-1:0]  count
);

    import bts_pkg::*;

    result_t               entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg;
    logic [OUTQ_CNT_W-1:0] count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + OUTQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(push_n) - (pop ? OUTQ_CNT_W'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage; the second word goes in the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + OUTQ_PTR_W'(1)] <= push_data1;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

[tb/bright_text_strip_patcher_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the bright text strip patcher: directed and random pixel streams.
module bright_text_strip_patcher_tb;
    import bts_pkg::*;

    // A pixel as it enters the block.
    typedef struct packed {
        logic   frame;
        pixel_t pix;
    } pixel_in_t;

    // One row of the directed stimulus. Typed rows run at width 1, so their column is 0.
    typedef struct {
        bit        reconfig;
        int        width_val;
        int        strip_val;
        pixel_in_t word;
        bit        typed;
        int        want_row;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   frame_start;
    logic [7:0]             in_red;
    logic [7:0]             in_green;
    logic [7:0]             in_blue;
    logic [7:0]             in_alpha;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             out_red;
    logic [7:0]             out_green;
    logic [7:0]             out_blue;
    logic [7:0]             out_alpha;
    logic                   is_strip_fix;
    logic [ROW_W-1:0]       pixel_row;
    logic [COL_W-1:0]       pixel_col;
    logic                   run_last;

    // Shadow of the registers and the position counters.
    int unsigned width_reg;
    int unsigned strip_reg;
    int unsigned col_pos;
    int unsigned row_pos;

    // Shadow of the strip store.
    pixel_t strip_pix [MAX_STRIP*MAX_WIDTH];
    bit     strip_mark [MAX_STRIP*MAX_WIDTH];

    result_t       awaited_words[$];
    directed_row_t directed [22];

    int idle_pct = 0;
    int stall_pct = 0;
    int bad_words = 0;
    int words_seen = 0;
    int patched_seen = 0;
    int pixels_sent = 0;
    int setups_run = 0;

    bright_text_strip_patcher dut (.*);

    always #5 clk = ~clk;

    // The receiver stalls at random with the current pressure.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare every accepted output word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_output();
    end

    initial
    begin
        #4_000_000;
        $display("Timeout with %0d words still awaited", awaited_words.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag_word(input string msg);
        if (bad_words < 60)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        bad_words++;
    endtask

    task automatic check_output();
        result_t want;
        if (awaited_words.size() == 0)
        begin
            flag_word($sformatf("word with no pixel behind it, row %0d col %0d fix %b",
                                pixel_row, pixel_col, is_strip_fix));
        end
        else
        begin
            want = awaited_words.pop_front();
            words_seen++;
            if (is_strip_fix)
                patched_seen++;
            if (out_red !== want.pix.red || out_green !== want.pix.green ||
                out_blue !== want.pix.blue || out_alpha !== want.pix.alpha ||
                is_strip_fix !== want.fix || pixel_row !== want.row ||
                pixel_col !== want.col || run_last !== want.last)
            begin
                flag_word($sformatf({"word %0d got %h%h%h%h fix %b r%0d c%0d last %b, ",
                                     "want %h%h%h%h fix %b r%0d c%0d last %b"},
                                    words_seen, out_red, out_green, out_blue, out_alpha,
                                    is_strip_fix, pixel_row, pixel_col, run_last,
                                    want.pix.red, want.pix.green, want.pix.blue,
                                    want.pix.alpha, want.fix, want.row, want.col, want.last));
            end
        end
    endtask

    // Works out the words that one accepted pixel causes and advances the position.
    function automatic int strip_patch_outcome(input pixel_in_t w, output result_t words [2]);
        int unsigned wd, st, row, col, py, y0, y1, x0, x1, yy, xx;
        int n;
        bit hit;
        n = 0;
        hit = 1'b0;
        words[0] = '0;
        words[1] = '0;
        wd = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        st = (strip_reg > MAX_STRIP) ? MAX_STRIP : strip_reg;
        if (w.frame)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        row = row_pos;
        col = col_pos;

        if (row < st)
        begin
            // Top strip: keep the pixel and whether it is bright.
            strip_pix[row*MAX_WIDTH + col] = w.pix;
            strip_mark[row*MAX_WIDTH + col] = w.pix.red > BRIGHT_LEVEL &&
                                              w.pix.green > BRIGHT_LEVEL &&
                                              w.pix.blue > BRIGHT_LEVEL;
        end
        else
        begin
            if (row < 2*st)
            begin
                // Patch the strip pixel above from its clipped 3x3 neighborhood.
                py = row - st;
                y0 = (py > 0) ? py - 1 : 0;
                y1 = (py + 1 < st) ? py + 1 : st - 1;
                x0 = (col > 0) ? col - 1 : 0;
                x1 = (col + 1 < wd) ? col + 1 : col;
                for (yy = y0; yy <= y1; yy++)
                    for (xx = x0; xx <= x1; xx++)
                        if (strip_mark[yy*MAX_WIDTH + xx])
                            hit = 1'b1;
                if (hit)
                begin
                    words[n].pix.red = w.pix.red;
                    words[n].pix.green = w.pix.green;
                    words[n].pix.blue = w.pix.blue;
                    words[n].pix.alpha = FULL_ALPHA;
                end
                else
                begin
                    words[n].pix = strip_pix[py*MAX_WIDTH + col];
                end
                words[n].fix = 1'b1;
                words[n].row = ROW_W'(py);
                words[n].col = COL_W'(col);
                words[n].last = 1'b0;
                n++;
            end
            words[n].pix = w.pix;
            words[n].fix = 1'b0;
            words[n].row = ROW_W'(row);
            words[n].col = COL_W'(col);
            words[n].last = 1'b1;
            n++;
        end

        if (col + 1 >= wd)
        begin
            col_pos = 0;
            if (row_pos < ROW_LIMIT)
                row_pos++;
        end
        else
        begin
            col_pos = col + 1;
        end
        return n;
    endfunction

    // Offers one pixel after a random gap and waits until the block takes it.
    task automatic send_pixel(input pixel_in_t w, input bit typed, input int want_row);
        result_t words [2];
        result_t typed_word;
        int gap, n, i;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_start <= w.frame;
        in_red <= w.pix.red;
        in_green <= w.pix.green;
        in_blue <= w.pix.blue;
        in_alpha <= w.pix.alpha;
        do @(posedge clk); while (in_stall);

        n = strip_patch_outcome(w, words);
        if (typed)
        begin
            typed_word.pix = w.pix;
            typed_word.fix = 1'b0;
            typed_word.row = ROW_W'(want_row);
            typed_word.col = '0;
            typed_word.last = 1'b1;
            awaited_words.push_back(typed_word);
        end
        else
        begin
            for (i = 0; i < n; i++)
                awaited_words.push_back(words[i]);
        end
        pixels_sent++;
    endtask

    // Lets the block go idle, then writes both registers.
    task automatic drain_and_configure(input int width_val, input int strip_val);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= CFG_DATA_W'(width_val);
        @(posedge clk);
        cfg_index <= REG_STRIP_ROWS;
        cfg_data <= {5'($urandom_range(0, 31)), 6'(strip_val)};
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = width_val & 32'h7FF;
        strip_reg = strip_val & 32'h3F;
        setups_run++;
    endtask

    function automatic void pick_idling(input int mode);
        case (mode)
            0:
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct = 66;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct = 0;
                stall_pct = 66;
            end
            default:
            begin
                idle_pct = 12;
                stall_pct = 12;
            end
        endcase
    endfunction

    // Mostly plain noise, sometimes near the brightness threshold.
    function automatic pixel_t random_pixel();
        pixel_t p;
        if ($urandom_range(0, 99) < 12)
        begin
            p.red = 8'($urandom_range(170, 255));
            p.green = 8'($urandom_range(170, 255));
            p.blue = 8'($urandom_range(170, 255));
        end
        else
        begin
            p.red = 8'($urandom);
            p.green = 8'($urandom);
            p.blue = 8'($urandom);
        end
        p.alpha = 8'($urandom);
        return p;
    endfunction

    function automatic pixel_in_t random_word(input bit frame);
        pixel_in_t w;
        w.frame = frame;
        w.pix = random_pixel();
        return w;
    endfunction

    // A whole image of strip, patch and plain rows; now and then cut short.
    task automatic send_image(input int wd, input int st);
        int height, total, i;
        height = 2*st + $urandom_range(0, 2);
        if (height == 0)
            height = 1;
        total = wd * height;
        if ($urandom_range(0, 9) == 0)
            total = $urandom_range(1, total);
        for (i = 0; i < total; i++)
            send_pixel(random_word(i == 0), 1'b0, 0);
    endtask

    function automatic directed_row_t drow(input bit rc, input int wv, input int sv,
                                           input bit f, input int r, input int g,
                                           input int b, input int a, input bit typed,
                                           input int row);
        directed_row_t d;
        d.reconfig = rc;
        d.width_val = wv;
        d.strip_val = sv;
        d.word.frame = f;
        d.word.pix.red = 8'(r);
        d.word.pix.green = 8'(g);
        d.word.pix.blue = 8'(b);
        d.word.pix.alpha = 8'(a);
        d.typed = typed;
        d.want_row = row;
        return d;
    endfunction

    initial
    begin
        int ph, wd, st, start_count, i;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= '0;
        in_valid <= 1'b0;
        frame_start <= 1'b0;
        in_red <= '0;
        in_green <= '0;
        in_blue <= '0;
        in_alpha <= '0;
        width_reg = 1;
        strip_reg = 0;
        col_pos = 0;
        row_pos = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset every pixel passes as its own row; then a 4-wide image with a
        // two-row strip: marks at threshold, hit and miss neighborhoods, clipped edges.
        directed = '{
            drow(0, 0, 0, 1,   0,   0,   0,   0, 1, 0),
            drow(0, 0, 0, 0, 255, 255, 255, 255, 1, 1),
            drow(0, 0, 0, 0, 180, 180, 180, 180, 1, 2),
            drow(0, 0, 0, 0, 181, 181, 181,   0, 1, 3),
            drow(0, 0, 0, 1,  12,  34,  56,  78, 1, 0),
            drow(1, 4, 2, 1, 200, 200, 200,  10, 0, 0),
            drow(0, 0, 0, 0, 181, 181, 180,  20, 0, 0),
            drow(0, 0, 0, 0, 180, 181, 181,  30, 0, 0),
            drow(0, 0, 0, 0,   1,   2,   3,  40, 0, 0),
            drow(0, 0, 0, 0,  50,  60,  70,  80, 0, 0),
            drow(0, 0, 0, 0,  90, 100, 110, 120, 0, 0),
            drow(0, 0, 0, 0, 181, 180, 255, 130, 0, 0),
            drow(0, 0, 0, 0, 250, 240, 230, 140, 0, 0),
            drow(0, 0, 0, 0,   5,   6,   7,   8, 0, 0),
            drow(0, 0, 0, 0,   9,  10,  11,  12, 0, 0),
            drow(0, 0, 0, 0,  13,  14,  15,  16, 0, 0),
            drow(0, 0, 0, 0,  17,  18,  19,  20, 0, 0),
            drow(0, 0, 0, 0, 255, 255, 255, 255, 0, 0),
            drow(0, 0, 0, 0,   0,   0,   0,   0, 0, 0),
            drow(0, 0, 0, 0, 181, 181, 181, 181, 0, 0),
            drow(0, 0, 0, 0, 100, 200,  50, 250, 0, 0),
            drow(0, 0, 0, 0, 255,   0, 255,   0, 0, 0)
        };
        foreach (directed[k])
        begin
            if (directed[k].reconfig)
                drain_and_configure(directed[k].width_val, directed[k].strip_val);
            send_pixel(directed[k].word, directed[k].typed, directed[k].want_row);
        end

        // Random images under each pressure pattern in turn.
        for (ph = 0; ph < 12; ph++)
        begin
            pick_idling(ph % 4);
            wd = $urandom_range(1, 12);
            st = $urandom_range(0, 5);
            drain_and_configure(wd, st);
            start_count = pixels_sent;
            while (pixels_sent - start_count < 30)
                send_image(wd, st);
        end

        // Width narrowed in the middle of an image: the column past the end wraps.
        pick_idling(2);
        drain_and_configure(9, 0);
        for (i = 0; i < 13; i++)
            send_pixel(random_word(i == 0), 1'b0, 0);
        drain_and_configure(3, 0);
        for (i = 0; i < 6; i++)
            send_pixel(random_word(1'b0), 1'b0, 0);

        // Width above the maximum counts as the maximum: one strip row across it,
        // then the first columns of the patch row below.
        pick_idling(3);
        drain_and_configure(2047, 1);
        for (i = 0; i < MAX_WIDTH + 6; i++)
            send_pixel(random_word(i == 0), 1'b0, 0);

        // Width zero counts as one and a strip above the maximum counts as the maximum.
        pick_idling(0);
        drain_and_configure(0, 63);
        for (i = 0; i < 2*MAX_STRIP + 6; i++)
            send_pixel(random_word(i == 0), 1'b0, 0);

        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d pixels over %0d register settings: strip, patch and plain rows,",
                 pixels_sent, setups_run);
        $display("widths 0 to 2047 and strips 0 to 63; %0d words, %0d patched.",
                 words_seen, patched_seen);
        if (bad_words == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
